>>> design/bpi_pkg.sv
package bpi_pkg;

    // Fraction scale: a fraction value f stands for f / 2^FRAC_BITS.
    localparam int FRAC_BITS = 8;

    // Fixed field widths of the channels.
    localparam int FRAC_W = 8;
    localparam int PIX_W  = 8;
    localparam int ROW_W  = 32;
    localparam int TAPS   = 4;

    // The weight magnitude is set by the larger of the scale and the fraction field.
    localparam int WIDE_FB = (FRAC_BITS > FRAC_W) ? FRAC_BITS : FRAC_W;

    // Datapath widths, all two's complement.
    localparam int WGT_W   = 3 * WIDE_FB + 4;
    localparam int PP_W    = WGT_W + PIX_W + 1;
    localparam int H_W     = WGT_W + PIX_W + 3;
    localparam int H_LO_W  = H_W / 2;
    localparam int H_HI_W  = H_W - H_LO_W;
    localparam int PLO_W   = WGT_W + H_LO_W + 1;
    localparam int PHI_W   = WGT_W + H_HI_W;
    localparam int ACC_W   = WGT_W + H_W + 2;

    // The exact result is the accumulator divided by 2^RES_SHIFT.
    localparam int RES_SHIFT = 6 * FRAC_BITS + 2;

    // Register stages from input to output register.
    localparam int NUM_STAGES = 9;

    typedef logic [FRAC_W-1:0]        t_frac;
    typedef logic signed [WGT_W-1:0]  t_wgt;
    typedef logic signed [PP_W-1:0]   t_pp;
    typedef logic signed [H_W-1:0]    t_h;
    typedef logic signed [PLO_W-1:0]  t_plo;
    typedef logic signed [PHI_W-1:0]  t_phi;
    typedef logic signed [ACC_W-1:0]  t_acc;

    localparam logic [PIX_W-1:0] PIX_MAX = '1;

    // Largest accumulator value whose exact result is not above the top sample.
    localparam t_acc SAT_LIMIT = t_acc'(PIX_MAX) <<< RES_SHIFT;

    // Load enables of the three stages of a weight unit.
    typedef struct packed {
        logic en_sq;
        logic en_cube;
        logic en_wgt;
    } t_wgt_en;

endpackage

>>> design/bpi_patch_if.sv
interface bpi_patch_if;
    import bpi_pkg::*;

    logic             valid;
    logic             ready;
    logic [ROW_W-1:0] row_0;
    logic [ROW_W-1:0] row_1;
    logic [ROW_W-1:0] row_2;
    logic [ROW_W-1:0] row_3;
    t_frac            frac_row;
    t_frac            frac_col;

    modport source (
        output valid, row_0, row_1, row_2, row_3, frac_row, frac_col,
        input  ready
    );

    modport sink (
        input  valid, row_0, row_1, row_2, row_3, frac_row, frac_col,
        output ready
    );

endinterface

>>> design/bpi_pixel_if.sv
interface bpi_pixel_if;
    import bpi_pkg::*;

    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel;
    logic             clamped;

    modport source (
        output valid, pixel, clamped,
        input  ready
    );

    modport sink (
        input  valid, pixel, clamped,
        output ready
    );

endinterface

>>> design/bicubic_patch_interpolator_top.sv
// Bicubic patch interpolator with the Catmull-Rom kernel.
//
// The input channel carries one transaction per 4x4 patch: four rows of four
// 8-bit samples (column 0 in the low byte) and a row and a column fraction.
// The output channel carries one transaction per patch: the interpolated
// sample, truncated toward zero and saturated to 0..255, and a flag that is
// set when the exact value lay outside that range.
// The datapath is a nine-stage pipeline: three stages build the kernel
// weights, then the column products, the row sums, the split row products
// and a three-stage accumulate and saturate. One patch is accepted per
// cycle unless every stage holds a patch while the receiver stalls.
// Each stage has its own valid bit and moves when the next stage can take
// its contents, so a stalled receiver holds the output register and empty
// stages still fill; ready drops only when every stage holds a patch.
// Reset clears all valid bits; no patch is in flight afterwards.
module bicubic_patch_interpolator_top (
    input logic         i_clk,
    input logic         i_rst_n,
    bpi_patch_if.sink   i_patch,
    bpi_pixel_if.source o_pix
);
    import bpi_pkg::*;

    localparam int LAST = NUM_STAGES - 1;

    logic [NUM_STAGES-1:0] r_v;
    logic [NUM_STAGES-1:0] n_v;
    logic [NUM_STAGES-1:0] adv;

    t_wgt_en wgt_en;
    t_wgt    wr [TAPS];
    t_wgt    wc [TAPS];

    logic [ROW_W-1:0] r0_row [TAPS];
    logic [ROW_W-1:0] r1_row [TAPS];
    logic [ROW_W-1:0] r2_row [TAPS];
    t_pp              r3_pp  [TAPS][TAPS];
    t_wgt             r3_wr  [TAPS];
    t_h               r4_h   [TAPS];
    t_wgt             r4_wr  [TAPS];
    t_plo             r5_plo [TAPS];
    t_phi             r5_phi [TAPS];
    t_acc             r6_prow [TAPS];
    t_acc             r7_s01;
    t_acc             r7_s23;
    logic [PIX_W-1:0] r8_pixel;
    logic             r8_clamped;

    t_acc             n_acc;
    logic             n_neg;
    logic             n_over;
    logic [PIX_W-1:0] n_pixel;

    // A stage may load when it is empty or its contents move on.
    always_comb begin
        adv[LAST] = !r_v[LAST] || o_pix.ready;
        for (int i = LAST - 1; i >= 0; i--) begin
            adv[i] = !r_v[i] || adv[i+1];
        end
    end

    assign i_patch.ready = adv[0];

    always_comb begin
        n_v[0] = adv[0] ? i_patch.valid : r_v[0];
        for (int i = 1; i < NUM_STAGES; i++) begin
            if (adv[i]) begin
                n_v[i] = r_v[i-1];
            end else begin
                n_v[i] = r_v[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= n_v;
        end
    end

    // Kernel weights for both directions, aligned with stage 2.
    assign wgt_en = '{en_sq: adv[0], en_cube: adv[1], en_wgt: adv[2]};

    bpi_weights u_wgt_row (
        .i_clk  (i_clk),
        .i_en   (wgt_en),
        .i_frac (i_patch.frac_row),
        .o_wgt  (wr)
    );

    bpi_weights u_wgt_col (
        .i_clk  (i_clk),
        .i_en   (wgt_en),
        .i_frac (i_patch.frac_col),
        .o_wgt  (wc)
    );

    // Samples ride along while the weights are built.
    always_ff @(posedge i_clk) begin
        if (adv[0]) begin
            r0_row[0] <= i_patch.row_0;
            r0_row[1] <= i_patch.row_1;
            r0_row[2] <= i_patch.row_2;
            r0_row[3] <= i_patch.row_3;
        end
        if (adv[1]) begin
            r1_row <= r0_row;
        end
        if (adv[2]) begin
            r2_row <= r1_row;
        end
    end

    // Column weight times each sample.
    always_ff @(posedge i_clk) begin
        if (adv[3]) begin
            for (int r = 0; r < TAPS; r++) begin
                for (int c = 0; c < TAPS; c++) begin
                    r3_pp[r][c] <= wc[c] * $signed({1'b0, r2_row[r][PIX_W*c +: PIX_W]});
                end
                r3_wr[r] <= wr[r];
            end
        end
    end

    // Horizontal pass: one sum per row.
    always_ff @(posedge i_clk) begin
        if (adv[4]) begin
            for (int r = 0; r < TAPS; r++) begin
                r4_h[r]  <= t_h'(r3_pp[r][0]) + t_h'(r3_pp[r][1])
                          + t_h'(r3_pp[r][2]) + t_h'(r3_pp[r][3]);
                r4_wr[r] <= r3_wr[r];
            end
        end
    end

    // Row weight times row sum, split into a low and a high partial product.
    always_ff @(posedge i_clk) begin
        if (adv[5]) begin
            for (int r = 0; r < TAPS; r++) begin
                r5_plo[r] <= r4_wr[r] * $signed({1'b0, r4_h[r][H_LO_W-1:0]});
                r5_phi[r] <= r4_wr[r] * $signed(r4_h[r][H_W-1:H_LO_W]);
            end
        end
    end

    // Recombine the partial products of each row.
    always_ff @(posedge i_clk) begin
        if (adv[6]) begin
            for (int r = 0; r < TAPS; r++) begin
                r6_prow[r] <= (t_acc'(r5_phi[r]) <<< H_LO_W) + t_acc'(r5_plo[r]);
            end
        end
    end

    // Vertical pass, first level of the adder tree.
    always_ff @(posedge i_clk) begin
        if (adv[7]) begin
            r7_s01 <= r6_prow[0] + r6_prow[1];
            r7_s23 <= r6_prow[2] + r6_prow[3];
        end
    end

    // Final sum, truncation and saturation.
    always_comb begin
        n_acc  = r7_s01 + r7_s23;
        n_neg  = n_acc[ACC_W-1];
        n_over = n_acc > SAT_LIMIT;
        if (n_neg) begin
            n_pixel = '0;
        end else if (n_over) begin
            n_pixel = PIX_MAX;
        end else begin
            n_pixel = n_acc[RES_SHIFT +: PIX_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[8]) begin
            r8_pixel   <= n_pixel;
            r8_clamped <= n_neg || n_over;
        end
    end

    assign o_pix.valid   = r_v[LAST];
    assign o_pix.pixel   = r8_pixel;
    assign o_pix.clamped = r8_clamped;

endmodule

>>> design/bpi_weights.sv
module bpi_weights (
    input  logic             i_clk,
    input  bpi_pkg::t_wgt_en i_en,
    input  bpi_pkg::t_frac   i_frac,
    output bpi_pkg::t_wgt    o_wgt [bpi_pkg::TAPS]
);
    import bpi_pkg::*;

    localparam t_wgt TWO_S3 = t_wgt'(1) <<< (3 * FRAC_BITS + 1);

    t_frac               r_f1;
    logic [2*FRAC_W-1:0] r_sq1;
    t_frac               r_f2;
    logic [2*FRAC_W-1:0] r_sq2;
    logic [3*FRAC_W-1:0] r_cube2;
    t_wgt                r_wgt [TAPS];

    t_wgt v_fs2;
    t_wgt v_sqs;
    t_wgt v_cube;
    t_wgt n_wgt [TAPS];

    // First stage squares the fraction.
    always_ff @(posedge i_clk) begin
        if (i_en.en_sq) begin
            r_f1  <= i_frac;
            r_sq1 <= i_frac * i_frac;
        end
    end

    // Second stage forms the cube.
    always_ff @(posedge i_clk) begin
        if (i_en.en_cube) begin
            r_f2    <= r_f1;
            r_sq2   <= r_sq1;
            r_cube2 <= r_sq1 * r_f1;
        end
    end

    // Catmull-Rom weights scaled by 2*S^3; only shifts and adds remain.
    always_comb begin
        v_fs2    = t_wgt'(r_f2) <<< (2 * FRAC_BITS);
        v_sqs    = t_wgt'(r_sq2) <<< FRAC_BITS;
        v_cube   = t_wgt'(r_cube2);
        n_wgt[0] = (v_sqs <<< 1) - v_fs2 - v_cube;
        n_wgt[1] = TWO_S3 - (v_sqs <<< 2) - v_sqs + (v_cube <<< 1) + v_cube;
        n_wgt[2] = v_fs2 + (v_sqs <<< 2) - (v_cube <<< 1) - v_cube;
        n_wgt[3] = v_cube - v_sqs;
    end

    always_ff @(posedge i_clk) begin
        if (i_en.en_wgt) begin
            for (int i = 0; i < TAPS; i++) begin
                r_wgt[i] <= n_wgt[i];
            end
        end
    end

    always_comb begin
        for (int i = 0; i < TAPS; i++) begin
            o_wgt[i] = r_wgt[i];
        end
    end

endmodule

>>> sim/bpi_pixel_check.sv
`timescale 1ns / 100ps

// Watches both channels of the interpolator, predicts the pixel for every
// accepted patch transaction and compares it with the next pixel transaction.
module bpi_pixel_check (
    input  logic i_clk,
    input  logic i_rst_n,
    bpi_patch_if i_patch,
    bpi_pixel_if i_pix,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_checked,
    output int   o_saturated
);
    import bpi_pkg::*;

    // The exact value is the accumulated sum divided by 2^VALUE_SHIFT.
    localparam int          VALUE_SHIFT = 6 * FRAC_BITS + 2;
    localparam logic [127:0] TOP_SAMPLE = (128'd1 << PIX_W) - 128'd1;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             clamped;
    } t_pix_res;

    t_pix_res pixel_q [$];
    t_pix_res got_pix;
    t_pix_res want_pix;
    int       fail_cnt;
    int       checked_cnt;
    int       saturated_cnt;

    // One Catmull-Rom tap, scaled by 2 * S^3 so that it is an exact integer.
    function automatic longint tap_weight(input logic [FRAC_W-1:0] frac, input int tap);
        longint s;
        longint s2;
        longint s3;
        longint f;
        longint f2;
        longint f3;
        longint w;
        s  = longint'(1) << FRAC_BITS;
        s2 = s * s;
        s3 = s2 * s;
        f  = longint'(frac);
        f2 = f * f;
        f3 = f2 * f;
        case (tap)
            0:       w = -f * s2 + 2 * f2 * s - f3;
            1:       w = 2 * s3 - 5 * f2 * s + 3 * f3;
            2:       w = f * s2 + 4 * f2 * s - 3 * f3;
            default: w = -f2 * s + f3;
        endcase
        return w;
    endfunction

    // Separable bicubic sum in exact integers, then truncate and saturate.
    function automatic t_pix_res predict_pixel(
        input logic [ROW_W-1:0]  r0,
        input logic [ROW_W-1:0]  r1,
        input logic [ROW_W-1:0]  r2,
        input logic [ROW_W-1:0]  r3,
        input logic [FRAC_W-1:0] fr,
        input logic [FRAC_W-1:0] fc
    );
        logic [ROW_W-1:0]    rows [4];
        longint              col_w [4];
        longint              hsum;
        logic signed [127:0] acc;
        logic signed [127:0] row_w;
        logic signed [127:0] h_wide;
        logic [127:0]        quo;
        logic [127:0]        rem;
        t_pix_res            res;
        rows[0] = r0;
        rows[1] = r1;
        rows[2] = r2;
        rows[3] = r3;
        for (int c = 0; c < TAPS; c++) begin
            col_w[c] = tap_weight(fc, c);
        end
        acc = '0;
        for (int r = 0; r < TAPS; r++) begin
            hsum = 0;
            for (int c = 0; c < TAPS; c++) begin
                hsum += col_w[c] * longint'(rows[r][PIX_W*c +: PIX_W]);
            end
            row_w  = tap_weight(fr, r);
            h_wide = hsum;
            acc    = acc + row_w * h_wide;
        end
        if (acc < 0) begin
            // Anything below zero, even a fraction of a step, clamps low.
            res.pixel   = '0;
            res.clamped = 1'b1;
        end else begin
            quo = acc >> VALUE_SHIFT;
            rem = acc & ((128'd1 << VALUE_SHIFT) - 128'd1);
            if (quo > TOP_SAMPLE || (quo == TOP_SAMPLE && rem != 128'd0)) begin
                res.pixel   = '1;
                res.clamped = 1'b1;
            end else begin
                res.pixel   = quo[PIX_W-1:0];
                res.clamped = 1'b0;
            end
        end
        return res;
    endfunction

    // Retire the oldest expectation on each pixel transaction, then queue the
    // prediction for each patch transaction.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pixel_q.delete();
            fail_cnt      = 0;
            checked_cnt   = 0;
            saturated_cnt = 0;
        end else begin
            if (i_pix.valid && i_pix.ready) begin
                got_pix.pixel   = i_pix.pixel;
                got_pix.clamped = i_pix.clamped;
                if (pixel_q.size() == 0) begin
                    $display("%0t: pixel %0d clamped %0d arrived with none expected",
                             $time, got_pix.pixel, got_pix.clamped);
                    fail_cnt++;
                end else begin
                    want_pix = pixel_q.pop_front();
                    checked_cnt++;
                    if (want_pix.clamped) begin
                        saturated_cnt++;
                    end
                    if (got_pix.pixel !== want_pix.pixel
                            || got_pix.clamped !== want_pix.clamped) begin
                        $display({"%0t: pixel mismatch, expected %0d clamped %0d,",
                                  " got %0d clamped %0d"},
                                 $time, want_pix.pixel, want_pix.clamped,
                                 got_pix.pixel, got_pix.clamped);
                        fail_cnt++;
                    end
                end
            end
            if (i_patch.valid && i_patch.ready) begin
                pixel_q.push_back(predict_pixel(i_patch.row_0, i_patch.row_1,
                                                i_patch.row_2, i_patch.row_3,
                                                i_patch.frac_row, i_patch.frac_col));
            end
        end
    end

    assign o_fail_count = fail_cnt;
    assign o_pending    = pixel_q.size();
    assign o_checked    = checked_cnt;
    assign o_saturated  = saturated_cnt;

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 100ps

// Drives patches into the interpolator under several idle and stall mixes
// and reports the verdict from the pixel checker.
module tb_top;
    import bpi_pkg::*;

    localparam int RAND_PER_PHASE = 232;
    localparam int WATCHDOG_LIMIT = 1000;

    logic i_clk;
    logic i_rst_n;

    bpi_patch_if patch_bus ();
    bpi_pixel_if pix_bus ();

    int fail_count;
    int pending;
    int checked;
    int saturated;
    int gap_pct;
    int stall_pct;
    logic calm;
    int sent_cnt;
    int quiet_cycles;

    bicubic_patch_interpolator_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_patch (patch_bus),
        .o_pix   (pix_bus)
    );

    bpi_pixel_check u_pixel_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_patch      (patch_bus),
        .i_pix        (pix_bus),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_saturated  (saturated)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Receiver stalls at random, except during calm stretches.
    always @(negedge i_clk) begin
        pix_bus.ready = calm || ($urandom_range(99) >= stall_pct);
    end

    // Watchdog: too long without any transaction on either channel ends the run.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            quiet_cycles = 0;
        end else if ((patch_bus.valid && patch_bus.ready) || (pix_bus.valid && pix_bus.ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no transaction for %0d cycles, %0d pixels still expected",
                         $time, quiet_cycles, pending);
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // Four samples into one row word, column 0 in the low byte.
    function automatic logic [ROW_W-1:0] pack_row(input logic [PIX_W-1:0] c0,
                                                  input logic [PIX_W-1:0] c1,
                                                  input logic [PIX_W-1:0] c2,
                                                  input logic [PIX_W-1:0] c3);
        return {c3, c2, c1, c0};
    endfunction

    // Fractions lean toward their end points now and then.
    function automatic logic [FRAC_W-1:0] pick_frac();
        logic [FRAC_W-1:0] f;
        case ($urandom_range(7))
            0:       f = '0;
            1:       f = '1;
            default: f = FRAC_W'($urandom_range(255));
        endcase
        return f;
    endfunction

    // Offer one patch transaction and hold it until the block takes it.
    task automatic send_patch(input logic [ROW_W-1:0] r0, input logic [ROW_W-1:0] r1,
                              input logic [ROW_W-1:0] r2, input logic [ROW_W-1:0] r3,
                              input logic [FRAC_W-1:0] fr, input logic [FRAC_W-1:0] fc);
        while (!calm && $urandom_range(99) < gap_pct) begin
            patch_bus.valid = 1'b0;
            @(negedge i_clk);
        end
        patch_bus.row_0    = r0;
        patch_bus.row_1    = r1;
        patch_bus.row_2    = r2;
        patch_bus.row_3    = r3;
        patch_bus.frac_row = fr;
        patch_bus.frac_col = fc;
        patch_bus.valid    = 1'b1;
        @(posedge i_clk);
        while (!patch_bus.ready) begin
            @(posedge i_clk);
        end
        sent_cnt++;
        @(negedge i_clk);
    endtask

    // Random patch: mostly raw noise, some smooth areas, some hard edges.
    task automatic send_random();
        logic [ROW_W-1:0] rows [4];
        int               style;
        int               base;
        int               v;
        style = $urandom_range(9);
        base  = $urandom_range(255);
        for (int r = 0; r < TAPS; r++) begin
            rows[r] = $urandom;
            for (int c = 0; c < TAPS; c++) begin
                if (style == 6 || style == 7) begin
                    v = base + int'($urandom_range(16)) - 8;
                    if (v < 0) v = 0;
                    if (v > 255) v = 255;
                    rows[r][PIX_W*c +: PIX_W] = v[PIX_W-1:0];
                end else if (style >= 8) begin
                    rows[r][PIX_W*c +: PIX_W] = $urandom_range(1) ? 8'hFF : 8'h00;
                end
            end
        end
        send_patch(rows[0], rows[1], rows[2], rows[3], pick_frac(), pick_frac());
    endtask

    initial begin
        logic [ROW_W-1:0] ramp0;
        logic [ROW_W-1:0] ramp1;
        logic [ROW_W-1:0] ramp2;
        logic [ROW_W-1:0] ramp3;
        i_rst_n            = 1'b0;
        patch_bus.valid    = 1'b0;
        patch_bus.row_0    = '0;
        patch_bus.row_1    = '0;
        patch_bus.row_2    = '0;
        patch_bus.row_3    = '0;
        patch_bus.frac_row = '0;
        patch_bus.frac_col = '0;
        pix_bus.ready      = 1'b0;
        gap_pct            = 0;
        stall_pct          = 0;
        calm               = 1'b0;
        sent_cnt           = 0;
        ramp0 = pack_row(8'd10, 8'd20, 8'd30, 8'd40);
        ramp1 = pack_row(8'd50, 8'd60, 8'd70, 8'd80);
        ramp2 = pack_row(8'd90, 8'd100, 8'd110, 8'd120);
        ramp3 = pack_row(8'd130, 8'd140, 8'd150, 8'd160);
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Flat patches at both ends of the sample range.
        send_patch('0, '0, '0, '0, 8'd0, 8'd0);
        send_patch('1, '1, '1, '1, 8'd0, 8'd0);
        send_patch('1, '1, '1, '1, 8'd255, 8'd255);
        send_patch('1, '1, '1, '1, 8'd128, 8'd128);
        send_patch('0, '0, '0, '0, 8'd255, 8'd1);
        // Zero fractions pass the inner sample; end-point fractions lean outward.
        send_patch(ramp0, ramp1, ramp2, ramp3, 8'd0, 8'd0);
        send_patch(ramp0, ramp1, ramp2, ramp3, 8'd255, 8'd0);
        send_patch(ramp0, ramp1, ramp2, ramp3, 8'd0, 8'd255);
        send_patch(ramp0, ramp1, ramp2, ramp3, 8'd255, 8'd255);
        send_patch(ramp0, ramp1, ramp2, ramp3, 8'd1, 8'd1);
        // Overshoot above the range along columns, along rows and in both.
        send_patch('0, pack_row(8'd0, 8'd255, 8'd255, 8'd0), '0, '0, 8'd0, 8'd128);
        send_patch('0, '1, '1, '0, 8'd128, 8'd0);
        send_patch('0, pack_row(8'd0, 8'd255, 8'd255, 8'd0),
                   pack_row(8'd0, 8'd255, 8'd255, 8'd0), '0, 8'd128, 8'd128);
        // Undershoot below zero, both deep and by half a step.
        send_patch('1, pack_row(8'd255, 8'd0, 8'd0, 8'd255),
                   pack_row(8'd255, 8'd0, 8'd0, 8'd255), '1, 8'd128, 8'd128);
        send_patch('1, pack_row(8'd4, 8'd0, 8'd0, 8'd4), '1, '1, 8'd0, 8'd128);
        // Half a step above the top sample, and exactly the top sample.
        send_patch('0, pack_row(8'd251, 8'd255, 8'd255, 8'd251), '0, '0, 8'd0, 8'd128);
        send_patch('0, pack_row(8'd0, 8'd255, 8'd0, 8'd0), '0, '0, 8'd0, 8'd0);
        // Alternating bit patterns on every field.
        send_patch(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 8'hAA, 8'h55);
        send_patch(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 8'h55, 8'hAA);
        send_patch('1, '0, '1, '0, 8'd64, 8'd192);

        // Random patches under each mix of source gaps and receiver stalls.
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin gap_pct = 0;  stall_pct = 0;  end
                1: begin gap_pct = 49; stall_pct = 0;  end
                2: begin gap_pct = 0;  stall_pct = 49; end
                default: begin gap_pct = 30; stall_pct = 30; end
            endcase
            for (int n = 0; n < RAND_PER_PHASE; n++) begin
                calm = (n % 50) < 8;
                send_random();
            end
        end
        calm            = 1'b0;
        patch_bus.valid = 1'b0;

        // Drain, then leave room for any stray pixel to show up.
        while (pending != 0) begin
            @(negedge i_clk);
        end
        repeat (3 * NUM_STAGES) @(negedge i_clk);

        $display("Sent %0d patches: directed corner cases, then random noise, smooth and edge",
                 sent_cnt);
        $display("patches under four gap and stall mixes; %0d pixels checked, %0d saturated.",
                 checked, saturated);
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
